// ----- src/prwf_pkg.sv -----
// Shared types and constants for the peer replay window filter.
package prwf_pkg;

    // Field widths of one beat
    localparam int ADDR_W       = 8;
    localparam int CTR_W        = 32;
    localparam int TIME_W       = 32;
    localparam int VERDICT_W    = 3;
    localparam int PEER_COUNT_W = 5;
    localparam int IN_DATA_W    = 72;
    localparam int OUT_DATA_W   = 16;

    // Seen window of older counters
    localparam int WIN_W    = 32;
    localparam int WIN_SH_W = $clog2(WIN_W);

    // Slot labels are wide enough for the largest table (64 slots)
    localparam int SLOT_ID_W = 6;

    // The peer count field saturates here
    localparam int PEER_COUNT_MAX = 31;

    typedef logic [VERDICT_W-1:0] verdict_t;

    localparam verdict_t VD_NEW       = 3'd0;
    localparam verdict_t VD_ADVANCED  = 3'd1;
    localparam verdict_t VD_IN_WINDOW = 3'd2;
    localparam verdict_t VD_DUPLICATE = 3'd3;
    localparam verdict_t VD_STALE     = 3'd4;

    // Message key broadcast to every slot cell
    typedef struct packed {
        logic [TIME_W-1:0] now;
        logic [CTR_W-1:0]  ctr;
        logic [ADDR_W-1:0] addr;
    } slot_key_t;

    // Search token that walks the row of cells, one cell per cycle
    typedef struct packed {
        logic                 valid;
        logic                 hit;
        logic [SLOT_ID_W-1:0] hit_id;
        verdict_t             hit_verdict;
        logic                 free;
        logic [SLOT_ID_W-1:0] free_id;
        logic                 have_lru;
        logic [SLOT_ID_W-1:0] lru_id;
        logic [TIME_W-1:0]    lru_time;
    } search_tok_t;

    // Write command broadcast to every slot cell
    typedef struct packed {
        logic                 valid;
        logic                 is_new;
        logic [SLOT_ID_W-1:0] id;
    } slot_upd_t;

endpackage

// ----- src/prwf_cell.sv -----
// One peer slot: holds the slot state, refines the search token and applies updates.
module prwf_cell
    import prwf_pkg::*;
#(
    parameter int CELL_ID = 0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  slot_key_t   key,
    input  search_tok_t tok_in,
    output search_tok_t tok_out,
    input  slot_upd_t   upd
);

    localparam logic [SLOT_ID_W-1:0] MY_ID = SLOT_ID_W'(CELL_ID);

    logic              used_reg;
    logic              used_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;
    logic [CTR_W-1:0]  top_reg;
    logic [CTR_W-1:0]  top_next;
    logic [WIN_W-1:0]  win_reg;
    logic [WIN_W-1:0]  win_next;
    logic [TIME_W-1:0] time_reg;
    logic [TIME_W-1:0] time_next;
    search_tok_t       tok_reg;
    search_tok_t       tok_next;

    logic              hit;
    verdict_t          verdict;
    logic [CTR_W-1:0]  ahead_diff;
    logic [CTR_W-1:0]  behind_diff;
    logic [WIN_W-1:0]  win_adv;
    logic [WIN_W-1:0]  win_mark;
    logic [WIN_SH_W-1:0] bit_pos;

    // Compare this slot against the key and classify the counter
    always_comb
    begin
        hit         = used_reg && (addr_reg == key.addr);
        ahead_diff  = key.ctr - top_reg;
        behind_diff = top_reg - key.ctr;
        bit_pos     = WIN_SH_W'(behind_diff - CTR_W'(1));
        win_mark    = win_reg | (WIN_W'(1) << bit_pos);
        if (ahead_diff >= CTR_W'(WIN_W))
        begin
            win_adv = '0;
        end
        else
        begin
            win_adv = (win_reg << ahead_diff[WIN_SH_W-1:0])
                    | (WIN_W'(1) << (ahead_diff[WIN_SH_W-1:0] - WIN_SH_W'(1)));
        end
        if (key.ctr > top_reg)
        begin
            verdict = VD_ADVANCED;
        end
        else if ((behind_diff == '0) || (behind_diff > CTR_W'(WIN_W)))
        begin
            verdict = VD_STALE;
        end
        else if (win_reg[bit_pos])
        begin
            verdict = VD_DUPLICATE;
        end
        else
        begin
            verdict = VD_IN_WINDOW;
        end
    end

    // Refine the search token: first match, first free slot, oldest slot
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid)
        begin
            if (hit && !tok_in.hit)
            begin
                tok_next.hit         = 1'b1;
                tok_next.hit_id      = MY_ID;
                tok_next.hit_verdict = verdict;
            end
            if (!used_reg && !tok_in.free)
            begin
                tok_next.free    = 1'b1;
                tok_next.free_id = MY_ID;
            end
            if (!tok_in.have_lru || (time_reg < tok_in.lru_time))
            begin
                tok_next.have_lru = 1'b1;
                tok_next.lru_id   = MY_ID;
                tok_next.lru_time = time_reg;
            end
        end
    end

    // Apply a write aimed at this slot
    always_comb
    begin
        used_next = used_reg;
        addr_next = addr_reg;
        top_next  = top_reg;
        win_next  = win_reg;
        time_next = time_reg;
        if (upd.valid && (upd.id == MY_ID))
        begin
            time_next = key.now;
            if (upd.is_new)
            begin
                used_next = 1'b1;
                addr_next = key.addr;
                top_next  = key.ctr;
                win_next  = '0;
            end
            else
            begin
                case (verdict)
                    VD_ADVANCED:
                    begin
                        top_next = key.ctr;
                        win_next = win_adv;
                    end
                    VD_IN_WINDOW:
                    begin
                        win_next = win_mark;
                    end
                    default:
                    begin
                        win_next = win_reg;
                    end
                endcase
            end
        end
    end

    // Hold the used flag and the token under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            tok_reg  <= '0;
        end
        else
        begin
            used_reg <= used_next;
            tok_reg  <= tok_next;
        end
    end

    // Slot payload, only read once the slot is used
    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        top_reg  <= top_next;
        win_reg  <= win_next;
        time_reg <= time_next;
    end

    assign tok_out = tok_reg;

endmodule

// ----- src/peer_replay_window_filter.sv -----
// Top level of the peer replay window filter: sequencer, output register and row of slot cells.
//
// Usage: each input beat on the s_ channel carries a peer address, its message counter
// and the current time in milliseconds. One result beat on the m_ channel follows for
// each input beat, giving accepted, the verdict and the number of used slots.
// Each slot of the table lives in its own cell; the cells form a row through which a
// search token walks one cell per cycle, collecting the matching slot, the first free
// slot and the slot heard least recently. The chosen cell is then written.
// One message is in flight at a time: a new input beat is taken only once the last
// message has walked the row of cells and the chosen cell has been written.
// s_tready is high only while the block is idle. The result sits in an output register,
// so the next input beat can be taken while a result waits for m_tready; a stalled
// receiver holds back the slot write of the following message until the register frees.
// Reset empties the table (all slots unused) and clears both channels.
module peer_replay_window_filter
    import prwf_pkg::*;
#(
    parameter int PEER_SLOTS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // peer_address[7:0], message_counter[39:8], now_ms[71:40]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata   // accepted[0], verdict[3:1], peer_count[8:4], zero[15:9]
);

    localparam int CNT_W = $clog2(PEER_SLOTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_WRITE  = 3'b100
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic                    launch_reg;
    logic                    launch_next;
    slot_key_t               key_reg;
    search_tok_t             res_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    out_acc_reg;
    verdict_t                out_verdict_reg;
    logic [PEER_COUNT_W-1:0] out_count_reg;

    search_tok_t             tok [PEER_SLOTS+1];
    slot_upd_t               upd;
    logic                    in_fire;
    logic                    out_free;
    logic                    write_fire;
    verdict_t                verdict;
    logic                    acc;
    logic [PEER_COUNT_W-1:0] count_sat;

    assign in_fire    = s_tvalid && s_tready;
    assign out_free   = !out_valid_reg || m_tready;
    assign write_fire = (state_reg == ST_WRITE) && out_free;

    // Launch an empty token into the first cell
    assign tok[0] = '{valid: launch_reg, default: '0};

    // Row of slot cells
    for (genvar i = 0; i < PEER_SLOTS; i++)
    begin : g_cell
        prwf_cell #(
            .CELL_ID (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .key     (key_reg),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1]),
            .upd     (upd)
        );
    end

    // Pick the target slot and form the result
    always_comb
    begin
        upd.valid  = write_fire;
        upd.is_new = !res_reg.hit;
        if (res_reg.hit)
        begin
            upd.id = res_reg.hit_id;
        end
        else if (res_reg.free)
        begin
            upd.id = res_reg.free_id;
        end
        else
        begin
            upd.id = res_reg.lru_id;
        end
        verdict = res_reg.hit ? res_reg.hit_verdict : VD_NEW;
        acc     = (verdict == VD_NEW) || (verdict == VD_ADVANCED) || (verdict == VD_IN_WINDOW);
        cnt_next = cnt_reg;
        if (write_fire && !res_reg.hit && res_reg.free)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (32'(cnt_next) > 32'(PEER_COUNT_MAX))
        begin
            count_sat = PEER_COUNT_W'(PEER_COUNT_MAX);
        end
        else
        begin
            count_sat = PEER_COUNT_W'(cnt_next);
        end
    end

    // Sequence one message: take, walk the row, write
    always_comb
    begin
        state_next     = state_reg;
        launch_next    = 1'b0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    launch_next = 1'b1;
                    state_next  = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (tok[PEER_SLOTS].valid)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            launch_reg    <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the key, the finished token and the result beat
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            key_reg <= s_tdata;
        end
        if ((state_reg == ST_SEARCH) && tok[PEER_SLOTS].valid)
        begin
            res_reg <= tok[PEER_SLOTS];
        end
        if (write_fire)
        begin
            out_acc_reg     <= acc;
            out_verdict_reg <= verdict;
            out_count_reg   <= count_sat;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_DATA_W - PEER_COUNT_W - VERDICT_W - 1)'(0),
                       out_count_reg, out_verdict_reg, out_acc_reg};

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the peer replay window filter, driven through its stream ports.
`timescale 1ns / 100ps

module testbench;
    import prwf_pkg::*;

    localparam int SLOTS        = 16;
    localparam int LATENCY      = SLOTS + 3;
    localparam int LIMIT_CYCLES = 500000;
    localparam int ADDR_POOL    = 20;
    localparam int RANDOM_ITEMS = 250;
    localparam int DIR_ROWS     = 27;

    // One received message as it enters the filter
    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [CTR_W-1:0]  ctr;
        logic [ADDR_W-1:0] addr;
    } peer_msg_t;

    // One verdict beat as it leaves the filter
    typedef struct packed {
        logic                    accepted;
        verdict_t                verdict;
        logic [PEER_COUNT_W-1:0] peer_count;
    } verdict_rec_t;

    // Directed row: message plus, where exact is set, the verdict typed in by hand
    typedef struct packed {
        logic [ADDR_W-1:0]       addr;
        logic [CTR_W-1:0]        ctr;
        logic [TIME_W-1:0]       now_ms;
        logic                    exact;
        logic                    accepted;
        verdict_t                verdict;
        logic [PEER_COUNT_W-1:0] peer_count;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // peer_address[7:0], message_counter[39:8], now_ms[71:40]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // accepted[0], verdict[3:1], peer_count[8:4], zero[15:9]

    // Shadow copy of the peer table
    logic              peer_live  [SLOTS];
    logic [ADDR_W-1:0] peer_addr  [SLOTS];
    logic [CTR_W-1:0]  peer_top   [SLOTS];
    logic [WIN_W-1:0]  peer_seen  [SLOTS];
    logic [TIME_W-1:0] peer_heard [SLOTS];

    verdict_rec_t      pending_verdicts [$];
    logic [ADDR_W-1:0] addr_pool [ADDR_POOL];
    logic [TIME_W-1:0] now_clock;
    int                send_idle_pct;
    int                recv_idle_pct;
    int                hold_left;
    int                errors;
    int                cycle_count;

    // Hand-checked opening sequence: window edges first, then fill and overflow the table
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, VD_NEW,       5'd1},
        '{8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, VD_NEW,       5'd2},
        '{8'h00, 32'h0000_0000, 32'd100,       1'b1, 1'b0, VD_STALE,     5'd2},
        '{8'h00, 32'h0000_0001, 32'd100,       1'b1, 1'b1, VD_ADVANCED,  5'd2},
        '{8'h00, 32'h0000_0021, 32'd100,       1'b1, 1'b1, VD_ADVANCED,  5'd2},
        '{8'h00, 32'h0000_0001, 32'd100,       1'b1, 1'b1, VD_IN_WINDOW, 5'd2},
        '{8'h00, 32'h0000_0001, 32'd100,       1'b1, 1'b0, VD_DUPLICATE, 5'd2},
        '{8'h00, 32'h0000_0000, 32'd100,       1'b1, 1'b0, VD_STALE,     5'd2},
        '{8'h00, 32'h0000_0040, 32'd100,       1'b0, 1'b0, VD_NEW,       5'd0},
        '{8'hFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, 1'b1, VD_IN_WINDOW, 5'd2},
        '{8'h10, 32'h8000_0000, 32'd7,         1'b0, 1'b0, VD_NEW,       5'd0},
        '{8'h11, 32'h4000_0001, 32'd7,         1'b0, 1'b0, VD_NEW,       5'd0},
        '{8'h12, 32'h2000_0002, 32'd7,         1'b0, 1'b0, VD_NEW,       5'd0},
        '{8'h13, 32'h1000_0003, 32'd7,         1'b0, 1'b0, VD_NEW,       5'd0},
        '{8'h14, 32'h0800_0004, 32'd7,         1'b0, 1'b0, VD_NEW,       5'd0},
        '{8'h15, 32'h0400_0005, 32'd7,         1'b0, 1'b0, VD_NEW,       5'd0},
        '{8'h16, 32'h0200_0006, 32'd7,         1'b0, 1'b0, VD_NEW,       5'd0},
        '{8'h17, 32'h0100_0007, 32'd7,         1'b0, 1'b0, VD_NEW,       5'd0},
        '{8'h18, 32'h0080_0008, 32'd7,         1'b0, 1'b0, VD_NEW,       5'd0},
        '{8'h19, 32'h0040_0009, 32'd7,         1'b0, 1'b0, VD_NEW,       5'd0},
        '{8'h1A, 32'h0020_000A, 32'd7,         1'b0, 1'b0, VD_NEW,       5'd0},
        '{8'h1B, 32'h0010_000B, 32'd7,         1'b0, 1'b0, VD_NEW,       5'd0},
        '{8'h1C, 32'h0008_000C, 32'd7,         1'b0, 1'b0, VD_NEW,       5'd0},
        '{8'h1D, 32'h0004_000D, 32'd7,         1'b0, 1'b0, VD_NEW,       5'd0},
        '{8'h80, 32'h0000_0005, 32'd200,       1'b1, 1'b1, VD_NEW,       5'd16},
        '{8'h81, 32'h0000_0006, 32'd200,       1'b1, 1'b1, VD_NEW,       5'd16},
        '{8'h10, 32'h8000_0000, 32'd200,       1'b1, 1'b1, VD_NEW,       5'd16}
    };

    peer_replay_window_filter #(
        .PEER_SLOTS (SLOTS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running clock
    always #5 clk = ~clk;

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("%0t: timed out with %0d verdicts outstanding", $realtime,
                     pending_verdicts.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Drive m_tready: hold off while the stall counter runs, else idle at random
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready = 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_tready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each verdict beat with the oldest expectation
    always @(posedge clk)
    begin
        verdict_rec_t want;
        verdict_rec_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.accepted   = m_tdata[0];
            got.verdict    = verdict_t'(m_tdata[3:1]);
            got.peer_count = m_tdata[8:4];
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected verdict beat, actual %h", $realtime, got);
                errors = errors + 1;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (got.accepted !== want.accepted)
                begin
                    $display("%0t: accepted mismatch, expected %0d actual %0d", $realtime,
                             want.accepted, got.accepted);
                    errors = errors + 1;
                end
                if (got.verdict !== want.verdict)
                begin
                    $display("%0t: verdict mismatch, expected %0d actual %0d", $realtime,
                             want.verdict, got.verdict);
                    errors = errors + 1;
                end
                if (got.peer_count !== want.peer_count)
                begin
                    $display("%0t: peer_count mismatch, expected %0d actual %0d", $realtime,
                             want.peer_count, got.peer_count);
                    errors = errors + 1;
                end
            end
        end
    end

    // Slot holding this address, or -1
    function automatic int find_peer(input logic [ADDR_W-1:0] addr);
        for (int i = 0; i < SLOTS; i++)
            if (peer_live[i] && peer_addr[i] == addr)
                return i;
        return -1;
    endfunction

    // Work out the verdict for one message and update the shadow table
    function automatic verdict_rec_t judge_message(input peer_msg_t msg);
        verdict_rec_t     res;
        int               slot;
        int               live;
        logic [CTR_W-1:0] gap;
        slot = find_peer(msg.addr);
        if (slot < 0)
        begin
            // take the first free slot, else the one heard least recently
            for (int i = SLOTS - 1; i >= 0; i--)
                if (!peer_live[i])
                    slot = i;
            if (slot < 0)
            begin
                slot = 0;
                for (int i = 1; i < SLOTS; i++)
                    if (peer_heard[i] < peer_heard[slot])
                        slot = i;
            end
            peer_live[slot]  = 1'b1;
            peer_addr[slot]  = msg.addr;
            peer_top[slot]   = msg.ctr;
            peer_seen[slot]  = '0;
            peer_heard[slot] = msg.now_ms;
            res.accepted = 1'b1;
            res.verdict  = VD_NEW;
        end
        else
        begin
            peer_heard[slot] = msg.now_ms;
            if (msg.ctr > peer_top[slot])
            begin
                gap = msg.ctr - peer_top[slot];
                if (gap >= WIN_W)
                    peer_seen[slot] = '0;
                else
                    peer_seen[slot] = (peer_seen[slot] << gap) | (32'd1 << (gap - 1));
                peer_top[slot] = msg.ctr;
                res.accepted = 1'b1;
                res.verdict  = VD_ADVANCED;
            end
            else
            begin
                gap = peer_top[slot] - msg.ctr;
                if (gap == 0 || gap > WIN_W)
                begin
                    res.accepted = 1'b0;
                    res.verdict  = VD_STALE;
                end
                else if (peer_seen[slot][gap - 1])
                begin
                    res.accepted = 1'b0;
                    res.verdict  = VD_DUPLICATE;
                end
                else
                begin
                    peer_seen[slot][gap - 1] = 1'b1;
                    res.accepted = 1'b1;
                    res.verdict  = VD_IN_WINDOW;
                end
            end
        end
        live = 0;
        for (int i = 0; i < SLOTS; i++)
            if (peer_live[i])
                live++;
        res.peer_count = PEER_COUNT_W'((live > PEER_COUNT_MAX) ? PEER_COUNT_MAX : live);
        return res;
    endfunction

    // Draw a message, mostly from a known peer with a counter near its top
    function automatic peer_msg_t draw_message();
        peer_msg_t        msg;
        int               slot;
        logic [CTR_W-1:0] top;
        if ($urandom_range(99) < 10)
            msg.addr = ADDR_W'($urandom);
        else
            msg.addr = addr_pool[$urandom_range(ADDR_POOL - 1)];
        // advance time slowly so that ties in heard time occur, with rare jumps
        if ($urandom_range(99) < 3)
            now_clock = $urandom;
        else
            now_clock = now_clock + $urandom_range(0, 4);
        msg.now_ms = now_clock;
        slot = find_peer(msg.addr);
        if (slot < 0)
            msg.ctr = ($urandom_range(1) == 1) ? $urandom : $urandom_range(0, 1000);
        else
        begin
            top = peer_top[slot];
            case ($urandom_range(0, 9))
                0, 1, 2: msg.ctr = top + $urandom_range(1, 31);
                3:       msg.ctr = top + $urandom_range(32, 40);
                4, 5, 6: msg.ctr = top - $urandom_range(1, 32);
                7:       msg.ctr = top;
                8:       msg.ctr = top - $urandom_range(33, 40);
                default: msg.ctr = $urandom;
            endcase
        end
        return msg;
    endfunction

    // Offer one beat, idling at random first, and record its verdict once taken
    task automatic send_msg(input peer_msg_t msg, input logic exact, input verdict_rec_t typed);
        verdict_rec_t res;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = msg;
        do
            @(posedge clk);
        while (!s_tready);
        res = judge_message(msg);
        pending_verdicts.push_back(exact ? typed : res);
    endtask

    // Drop the offer and hold the sender until every verdict is back
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // Random traffic for one idling setting
    task automatic run_random(input int count);
        verdict_rec_t none;
        none = '0;
        for (int n = 0; n < count; n++)
            send_msg(draw_message(), 1'b0, none);
    endtask

    initial
    begin
        peer_msg_t    msg;
        verdict_rec_t typed;
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        hold_left     = 0;
        errors        = 0;
        cycle_count   = 0;
        now_clock     = 32'd1000;
        send_idle_pct = 22;
        recv_idle_pct = 49;
        for (int i = 0; i < SLOTS; i++)
        begin
            peer_live[i]  = 1'b0;
            peer_addr[i]  = '0;
            peer_top[i]   = '0;
            peer_seen[i]  = '0;
            peer_heard[i] = '0;
        end
        for (int i = 0; i < ADDR_POOL; i++)
            addr_pool[i] = ADDR_W'($urandom);

        // Hold reset at the start, then release it
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed rows
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            msg.addr         = dir_rows[r].addr;
            msg.ctr          = dir_rows[r].ctr;
            msg.now_ms       = dir_rows[r].now_ms;
            typed.accepted   = dir_rows[r].accepted;
            typed.verdict    = dir_rows[r].verdict;
            typed.peer_count = dir_rows[r].peer_count;
            send_msg(msg, dir_rows[r].exact, typed);
        end
        wait_drained();

        // Sender idles less than the receiver
        run_random(RANDOM_ITEMS / 2);
        // Stall the receiver for a long stretch while beats keep coming
        hold_left = 400;
        typed = '0;
        for (int n = 0; n < 8; n++)
            send_msg(draw_message(), 1'b0, typed);
        wait_drained();
        run_random(RANDOM_ITEMS / 2);
        wait_drained();

        // Receiver idles less than the sender
        send_idle_pct = 49;
        recv_idle_pct = 22;
        run_random(RANDOM_ITEMS);
        wait_drained();

        // Full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(RANDOM_ITEMS);

        @(negedge clk);
        s_tvalid = 1'b0;
        wait_drained();
        repeat (LATENCY + 20) @(posedge clk);

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
